// File: rtl/mvt_pkg.sv
// shared types, constants and register codes for the 4x4 matrix-vector transform
package mvt_pkg;

    localparam int unsigned RowCount   = 4;
    localparam int unsigned CompW      = 32;
    localparam int unsigned CoefW      = 16;
    localparam int unsigned RowW       = RowCount * CoefW;
    localparam int unsigned ProdW      = CoefW + CompW;
    localparam int unsigned SumW       = ProdW + 2;
    localparam int unsigned CoefFrac   = 12;
    localparam int unsigned QuotW      = SumW - CoefFrac;
    localparam int unsigned CfgIdxW    = 2;

    // half of one output lsb in product units, added before the floor shift
    localparam logic signed [SumW-1:0] RoundHalf = SumW'(2048);

    // identity matrix, 1.0 in S3.12 on the diagonal
    localparam logic [RowW-1:0] RowReset [RowCount] = '{
        64'h0000_0000_0000_1000,
        64'h0000_0000_1000_0000,
        64'h0000_1000_0000_0000,
        64'h1000_0000_0000_0000
    };

    typedef logic signed [CompW-1:0] comp_t;
    typedef logic [RowW-1:0]         row_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_ROW0 = 2'd0,
        CFG_ROW1 = 2'd1,
        CFG_ROW2 = 2'd2,
        CFG_ROW3 = 2'd3
    } cfg_idx_t;

    // per-stage load enables shared by all lanes
    typedef struct packed {
        logic en_mul;
        logic en_sum;
        logic en_sat;
    } lane_ctl_t;

endpackage

// File: rtl/mvt_if.sv
// request channel interfaces: vector in, transformed vector out, register writes
interface mvt_vec_if;
    logic                valid;
    logic                ready;
    mvt_pkg::comp_t      vec_x;
    mvt_pkg::comp_t      vec_y;
    mvt_pkg::comp_t      vec_z;
    mvt_pkg::comp_t      vec_w;

    modport source (output valid, output vec_x, output vec_y, output vec_z, output vec_w,
                    input ready);
    modport sink   (input valid, input vec_x, input vec_y, input vec_z, input vec_w,
                    output ready);
endinterface

interface mvt_res_if;
    logic                valid;
    logic                ready;
    mvt_pkg::comp_t      out_x;
    mvt_pkg::comp_t      out_y;
    mvt_pkg::comp_t      out_z;
    mvt_pkg::comp_t      out_w;
    logic                saturated;

    modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                    output saturated, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z, input out_w,
                    input saturated, output ready);
endinterface

interface mvt_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mvt_pkg::CfgIdxW-1:0]   index;
    mvt_pkg::row_t                 data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/mvt_lane.sv
// one matrix row dot product: multiply, sum with rounding, floor shift and saturate
module mvt_lane (
    input  logic                clk,
    input  mvt_pkg::lane_ctl_t  ctl,
    input  mvt_pkg::row_t       row,
    input  mvt_pkg::comp_t      vec [mvt_pkg::RowCount],
    output mvt_pkg::comp_t      q,
    output logic                clip
);

    logic signed [mvt_pkg::ProdW-1:0] prod_reg  [mvt_pkg::RowCount];
    logic signed [mvt_pkg::ProdW-1:0] prod_next [mvt_pkg::RowCount];
    logic signed [mvt_pkg::SumW-1:0]  sum_reg;
    logic signed [mvt_pkg::SumW-1:0]  sum_next;
    logic signed [mvt_pkg::QuotW-1:0] quot;
    mvt_pkg::comp_t                   q_reg;
    mvt_pkg::comp_t                   q_next;
    logic                             clip_reg;
    logic                             clip_next;

    // one 16x32 signed multiplier per element
    for (genvar j = 0; j < mvt_pkg::RowCount; j++) begin : g_mul
        logic signed [mvt_pkg::CoefW-1:0] coef;
        assign coef         = signed'(row[j*mvt_pkg::CoefW +: mvt_pkg::CoefW]);
        assign prod_next[j] = mvt_pkg::ProdW'(coef) * mvt_pkg::ProdW'(vec[j]);
    end

    assign sum_next = mvt_pkg::SumW'(prod_reg[0]) + mvt_pkg::SumW'(prod_reg[1])
                    + mvt_pkg::SumW'(prod_reg[2]) + mvt_pkg::SumW'(prod_reg[3])
                    + mvt_pkg::RoundHalf;

    // dropping the low bits of a two's complement value is a floor division
    assign quot = signed'(sum_reg[mvt_pkg::SumW-1:mvt_pkg::CoefFrac]);

    always_comb
    begin
        clip_next = 1'b0;
        q_next    = quot[mvt_pkg::CompW-1:0];
        // in range only when the bits above the result are a sign copy
        if (quot[mvt_pkg::QuotW-1:mvt_pkg::CompW-1] != '0 &&
            quot[mvt_pkg::QuotW-1:mvt_pkg::CompW-1] != '1)
        begin
            clip_next = 1'b1;
            q_next    = quot[mvt_pkg::QuotW-1] ? {1'b1, {(mvt_pkg::CompW-1){1'b0}}}
                                               : {1'b0, {(mvt_pkg::CompW-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_mul)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.en_sum)
        begin
            sum_reg <= sum_next;
        end
        if (ctl.en_sat)
        begin
            q_reg    <= q_next;
            clip_reg <= clip_next;
        end
    end

    assign q    = q_reg;
    assign clip = clip_reg;

endmodule

// File: rtl/mvt_merge.sv
// output register: gathers the four lanes, merges the clip flags, holds under stall
module mvt_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                lane_valid,
    input  mvt_pkg::comp_t      lane_q    [mvt_pkg::RowCount],
    input  logic [mvt_pkg::RowCount-1:0] lane_clip,
    output logic                en_out,
    mvt_res_if.source           res
);

    logic           valid_reg;
    logic           valid_next;
    mvt_pkg::comp_t q_reg [mvt_pkg::RowCount];
    logic           sat_reg;

    assign en_out     = !valid_reg || res.ready;
    assign valid_next = en_out ? lane_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            q_reg   <= lane_q;
            sat_reg <= |lane_clip;
        end
    end

    assign res.valid     = valid_reg;
    assign res.out_x     = q_reg[0];
    assign res.out_y     = q_reg[1];
    assign res.out_z     = q_reg[2];
    assign res.out_w     = q_reg[3];
    assign res.saturated = sat_reg;

endmodule

// File: rtl/mat4_vec4_transform.sv
// top level of the 4x4 matrix times vec4 transform with row registers and lane pipeline
//
// channels
//   in_vec  : one request carries a signed Q16.16 vector (vec_x, vec_y, vec_z, vec_w)
//   out_res : one request per input, out_x..out_w are the four row dot products in
//             signed Q16.16, saturated is set when any component clipped
//   cfg     : writes one 64-bit matrix row, index 0..3 selects the row, each row packs
//             four S3.12 coefficients with element 0 in the low 16 bits; always ready,
//             the user must change rows only while no vector is in flight (not checked)
// throughput and pipeline
//   one vector per clock while out_res takes results; a result reaches out_res
//   through four registers (multiply, sum and round, saturate, output)
//   the four lanes each own four 16x32 multipliers, one lane per matrix row
// reset
//   rst_n clears every stage valid and loads the identity matrix into the rows
// stall
//   when out_res is not ready the pipeline compacts its empty stages and keeps
//   accepting until all four stages hold a vector; then in_vec.ready drops until
//   the receiver takes the waiting result
module mat4_vec4_transform (
    input  logic       clk,
    input  logic       rst_n,
    mvt_vec_if.sink    in_vec,
    mvt_res_if.source  out_res,
    mvt_cfg_if.sink    cfg
);

    // matrix rows
    mvt_pkg::row_t row_reg  [mvt_pkg::RowCount];
    mvt_pkg::row_t row_next [mvt_pkg::RowCount];

    // stage valids: multiply, sum, saturate
    logic v_mul_reg, v_mul_next;
    logic v_sum_reg, v_sum_next;
    logic v_sat_reg, v_sat_next;

    logic                         en_out;
    mvt_pkg::lane_ctl_t           ctl;
    mvt_pkg::comp_t               vec    [mvt_pkg::RowCount];
    mvt_pkg::comp_t               lane_q [mvt_pkg::RowCount];
    logic [mvt_pkg::RowCount-1:0] lane_clip;

    // register writes
    assign cfg.ready = 1'b1;

    always_comb
    begin
        row_next = row_reg;
        if (cfg.valid)
        begin
            unique case (mvt_pkg::cfg_idx_t'(cfg.index))
                mvt_pkg::CFG_ROW0: row_next[0] = cfg.data;
                mvt_pkg::CFG_ROW1: row_next[1] = cfg.data;
                mvt_pkg::CFG_ROW2: row_next[2] = cfg.data;
                mvt_pkg::CFG_ROW3: row_next[3] = cfg.data;
                default:           row_next    = row_reg;
            endcase
        end
    end

    // a stage loads when it is empty or its content moves on
    assign ctl.en_sat = !v_sat_reg || en_out;
    assign ctl.en_sum = !v_sum_reg || ctl.en_sat;
    assign ctl.en_mul = !v_mul_reg || ctl.en_sum;

    assign in_vec.ready = ctl.en_mul;

    assign v_mul_next = ctl.en_mul ? in_vec.valid : v_mul_reg;
    assign v_sum_next = ctl.en_sum ? v_mul_reg    : v_sum_reg;
    assign v_sat_next = ctl.en_sat ? v_sum_reg    : v_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= mvt_pkg::RowReset;
            v_mul_reg <= 1'b0;
            v_sum_reg <= 1'b0;
            v_sat_reg <= 1'b0;
        end
        else
        begin
            row_reg   <= row_next;
            v_mul_reg <= v_mul_next;
            v_sum_reg <= v_sum_next;
            v_sat_reg <= v_sat_next;
        end
    end

    assign vec[0] = in_vec.vec_x;
    assign vec[1] = in_vec.vec_y;
    assign vec[2] = in_vec.vec_z;
    assign vec[3] = in_vec.vec_w;

    // one lane per matrix row
    for (genvar i = 0; i < mvt_pkg::RowCount; i++) begin : g_lane
        mvt_lane u_lane (
            .clk  (clk),
            .ctl  (ctl),
            .row  (row_reg[i]),
            .vec  (vec),
            .q    (lane_q[i]),
            .clip (lane_clip[i])
        );
    end

    // merge lanes into the result and hold it for the receiver
    mvt_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .lane_valid (v_sat_reg),
        .lane_q     (lane_q),
        .lane_clip  (lane_clip),
        .en_out     (en_out),
        .res        (out_res)
    );

endmodule

// File: tb/mvt_transform_checker.sv
// checker for the matrix-vector transform: predicts each result and compares it field by field
module mvt_transform_checker
    import mvt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mvt_vec_if          vec,
    mvt_res_if          res,
    mvt_cfg_if          cfg,
    output int unsigned mismatch_count,
    output int unsigned results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CoefW-1:0] COEF_ONE    = 16'h1000;
    localparam longint           HALF_LSB    = 2048;
    localparam int unsigned      PRINT_LIMIT = 40;

    typedef struct packed {
        comp_t x;
        comp_t y;
        comp_t z;
        comp_t w;
        logic  sat;
    } vertex_out_t;

    row_t        coef_rows [RowCount];
    vertex_out_t expected_vertices [$];
    vertex_out_t oldest;
    int unsigned mismatches = 0;
    int unsigned pending_cnt = 0;

    assign mismatch_count  = mismatches;
    assign results_pending = pending_cnt;

    task automatic note_mismatch(input string what);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // one row dot product: exact sum, round half up, floor shift, clip to 32 bits
    function automatic comp_t row_dot(input row_t row, input comp_t vx, input comp_t vy,
                                      input comp_t vz, input comp_t vw,
                                      inout logic clipped);
        longint acc;
        longint q;
        acc = longint'($signed(row[15:0]))  * longint'(vx)
            + longint'($signed(row[31:16])) * longint'(vy)
            + longint'($signed(row[47:32])) * longint'(vz)
            + longint'($signed(row[63:48])) * longint'(vw);
        q = (acc + HALF_LSB) >>> CoefFrac;
        if (q > longint'(32'sh7FFF_FFFF)) begin
            clipped = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (q < -longint'(64'sh8000_0000)) begin
            clipped = 1'b1;
            return 32'sh8000_0000;
        end
        return comp_t'(q);
    endfunction

    function automatic vertex_out_t transform_vertex(input comp_t vx, input comp_t vy,
                                                     input comp_t vz, input comp_t vw);
        vertex_out_t r;
        logic        clipped;
        clipped = 1'b0;
        r.x   = row_dot(coef_rows[0], vx, vy, vz, vw, clipped);
        r.y   = row_dot(coef_rows[1], vx, vy, vz, vw, clipped);
        r.z   = row_dot(coef_rows[2], vx, vy, vz, vw, clipped);
        r.w   = row_dot(coef_rows[3], vx, vy, vz, vw, clipped);
        r.sat = clipped;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < RowCount; i++)
                coef_rows[i] = row_t'(COEF_ONE) << (CoefW * i);
            expected_vertices.delete();
            pending_cnt <= 0;
        end
        else begin
            if (cfg.valid && cfg.ready)
                coef_rows[cfg.index] = cfg.data;
            if (vec.valid && vec.ready)
                expected_vertices.push_back(
                    transform_vertex(vec.vec_x, vec.vec_y, vec.vec_z, vec.vec_w));
            if (res.valid && res.ready) begin
                if (expected_vertices.size() == 0) begin
                    note_mismatch("result with no request waiting");
                end
                else begin
                    oldest = expected_vertices.pop_front();
                    if (res.out_x !== oldest.x)
                        note_mismatch($sformatf("out_x got %h want %h", res.out_x, oldest.x));
                    if (res.out_y !== oldest.y)
                        note_mismatch($sformatf("out_y got %h want %h", res.out_y, oldest.y));
                    if (res.out_z !== oldest.z)
                        note_mismatch($sformatf("out_z got %h want %h", res.out_z, oldest.z));
                    if (res.out_w !== oldest.w)
                        note_mismatch($sformatf("out_w got %h want %h", res.out_w, oldest.w));
                    if (res.saturated !== oldest.sat)
                        note_mismatch($sformatf("saturated got %b want %b",
                                                res.saturated, oldest.sat));
                end
            end
            pending_cnt <= expected_vertices.size();
        end
    end

endmodule

// File: tb/mat4_vec4_transform_tb.sv
// testbench top for the 4x4 matrix-vector transform: clock, reset, stimulus and verdict
module mat4_vec4_transform_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mvt_pkg::*;

    // comp extremes in signed Q16.16
    localparam comp_t COMP_MAX = 32'sh7FFF_FFFF;
    localparam comp_t COMP_MIN = 32'sh8000_0000;
    localparam comp_t COMP_ONE = 32'sh0001_0000;

    // coefficient extremes in S3.12
    localparam logic [CoefW-1:0] COEF_MAX  = 16'h7FFF;
    localparam logic [CoefW-1:0] COEF_MIN  = 16'h8000;
    localparam logic [CoefW-1:0] COEF_ONE  = 16'h1000;
    localparam logic [CoefW-1:0] COEF_NEG1 = 16'hF000;
    localparam logic [CoefW-1:0] COEF_LSB  = 16'h0001;

    localparam int PHASES          = 4;
    localparam int BLOCKS_PER      = 4;
    localparam int ITEMS_PER_BLOCK = 96;
    localparam int LONG_HOLD       = 300;     // receiver hold-off, in cycles
    localparam int SETTLE_CYCLES   = 8;       // pipeline is four deep
    localparam int CYCLE_LIMIT     = 200000;

    logic clk;
    logic rst_n;

    mvt_vec_if vec_ch ();
    mvt_res_if res_ch ();
    mvt_cfg_if cfg_ch ();

    int unsigned mismatch_count;
    int unsigned results_pending;

    // knobs shared between the sender and the receiver processes
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int cycle_count    = 0;

    mat4_vec4_transform u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vec  (vec_ch),
        .out_res (res_ch),
        .cfg     (cfg_ch)
    );

    mvt_transform_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .vec             (vec_ch),
        .res             (res_ch),
        .cfg             (cfg_ch),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, plus a long hold-off whenever the main flow asks for one
    initial
    begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_requests != holds_served) begin
                holds_served++;
                hold_left = LONG_HOLD;
                res_ch.ready <= 1'b0;
            end
            else begin
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog, the run is far shorter than this even with every stall phase
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // one vertex request; valid stays high on return so back-to-back requests stream
    task automatic send_vec(input comp_t x, input comp_t y, input comp_t z, input comp_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            vec_ch.valid <= 1'b0;
            @(posedge clk);
        end
        vec_ch.valid <= 1'b1;
        vec_ch.vec_x <= x;
        vec_ch.vec_y <= y;
        vec_ch.vec_z <= z;
        vec_ch.vec_w <= w;
        @(posedge clk);
        while (!vec_ch.ready)
            @(posedge clk);
    endtask

    // stop sending and let every expected result come out
    task automatic wait_drained();
        vec_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write request, valid left high for the caller to lower
    task automatic cfg_write(input cfg_idx_t idx, input row_t data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    // full matrix load, only called while the pipeline is empty
    task automatic load_matrix(input row_t r0, input row_t r1, input row_t r2, input row_t r3);
        cfg_write(CFG_ROW0, r0);
        cfg_write(CFG_ROW1, r1);
        cfg_write(CFG_ROW2, r2);
        cfg_write(CFG_ROW3, r3);
        cfg_ch.valid <= 1'b0;
    endtask

    // components: mostly full range, some small values, some extremes
    function automatic comp_t rand_comp();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: return COMP_MAX;
                    1: return COMP_MIN;
                    2: return '0;
                    3: return '1;
                    default: return COMP_ONE;
                endcase
            end
            1, 2, 3: return comp_t'(int'($urandom_range(1 << 20)) - (1 << 19));
            default: return comp_t'($urandom());
        endcase
    endfunction

    // coefficients: mix of realistic values within +-2.0, extremes and raw bits
    function automatic logic [CoefW-1:0] rand_coef();
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(6))
                    0: return COEF_MAX;
                    1: return COEF_MIN;
                    2: return '0;
                    3: return COEF_ONE;
                    4: return COEF_NEG1;
                    5: return COEF_LSB;
                    default: return '1;
                endcase
            end
            1, 2, 3, 4: return CoefW'(int'($urandom_range(16384)) - 8192);
            default: return CoefW'($urandom());
        endcase
    endfunction

    function automatic row_t rand_row();
        if ($urandom_range(3) == 0)
            return {$urandom(), $urandom()};
        return {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
    endfunction

    initial
    begin
        // every block input known from time zero
        rst_n        = 1'b0;
        vec_ch.valid = 1'b0;
        vec_ch.vec_x = '0;
        vec_ch.vec_y = '0;
        vec_ch.vec_z = '0;
        vec_ch.vec_w = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_ROW0;
        cfg_ch.data  = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity after reset: every vector passes through unchanged
        send_vec('0, '0, '0, '0);
        send_vec(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
        send_vec(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
        send_vec('1, comp_t'(1), COMP_ONE, 32'sh8000_0001);
        wait_drained();

        // extreme rows: all max, all min, one lsb in element 0, all minus one lsb
        load_matrix({4{COEF_MAX}}, {4{COEF_MIN}}, row_t'(COEF_LSB), '1);
        send_vec(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);   // clip high and low
        send_vec(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
        send_vec(COMP_MIN, '0, '0, '0);                     // min times min clips high
        send_vec(COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN);   // lanes nearly cancel
        send_vec(32'sd2048, '0, '0, '0);                    // tie rounds up to one
        send_vec(-32'sd2048, '0, '0, '0);                   // tie rounds up to zero
        send_vec(-32'sd2049, '0, '0, '0);                   // just below the tie
        send_vec(32'sd2047, '0, '0, '0);
        wait_drained();

        // all-ones-point-zero and minus one rows, sums of four products
        load_matrix({4{COEF_ONE}}, {4{COEF_NEG1}}, {COEF_NEG1, COEF_ONE, COEF_NEG1, COEF_ONE},
                    '0);
        send_vec(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
        send_vec(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
        send_vec(COMP_ONE, -COMP_ONE, COMP_ONE, 32'sh4000_0000);

        // random part: one idle profile per phase, a fresh matrix per block
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            for (int blk = 0; blk < BLOCKS_PER; blk++)
            begin
                // sender pauses here until every result is back
                wait_drained();
                if (blk == 0 && phase == 1)
                    load_matrix({4{COEF_MAX}}, {4{COEF_MAX}}, {4{COEF_MAX}}, {4{COEF_MAX}});
                else if (blk == 0 && phase == 2)
                    load_matrix({4{COEF_MIN}}, {4{COEF_MIN}}, {4{COEF_MIN}}, {4{COEF_MIN}});
                else if (blk == 0 && phase == 3)
                    load_matrix('0, '0, '0, '0);
                else
                    load_matrix(rand_row(), rand_row(), rand_row(), rand_row());

                // long receiver hold while the sender keeps offering, fills the pipeline
                if (blk == 1 && phase == 0)
                    hold_requests++;

                for (int n = 0; n < ITEMS_PER_BLOCK; n++)
                    send_vec(rand_comp(), rand_comp(), rand_comp(), rand_comp());
            end
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
